// ===== sv/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants for the Cartesian to spherical converter
// Channel payload types, CORDIC arctangent table, gain constant and angle codes.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

  // Fixed field widths of the channels.
  localparam int FIELD_BITS = 24;
  localparam int TAG_BITS   = 2;

  // Defaults for the top-level parameters.
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int DATA_BITS_DEF    = 24;

  // Fraction bits carried on the magnitudes during both passes.
  localparam int GUARD = 6;

  // Angle accumulator in 2^-32 turn, and the rounded angle in 2^-24 turn.
  localparam int ACC_BITS = 34;
  localparam int ANG_BITS = 23;

  // Inverse CORDIC gain in Q31.
  localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

  // Angle codes in 2^-24 turn.
  localparam logic [23:0] QUARTER_TURN       = 24'd4194304;
  localparam logic [23:0] HALF_TURN          = 24'd8388608;
  localparam logic [23:0] THREE_QUARTER_TURN = 24'd12582912;

  // Arctangent of 2^-i in 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Input request payload.
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] x_in;
    logic signed [FIELD_BITS-1:0] y_in;
    logic signed [FIELD_BITS-1:0] z_in;
    logic        [TAG_BITS-1:0]   coord_tag;
  } c2s_in_t;

  // Result payload.
  typedef struct packed {
    logic        [FIELD_BITS-1:0] radius;
    logic        [FIELD_BITS-1:0] azimuth;
    logic signed [FIELD_BITS-1:0] elevation;
    logic        [TAG_BITS-1:0]   tag_out;
  } c2s_out_t;

  // Control that travels with each CORDIC stage.
  typedef struct packed {
    logic valid;
    logic skip;
  } c2s_ctl_t;

  // Sign and zero flags of the input vector, with the tag.
  typedef struct packed {
    logic                x_neg;
    logic                y_neg;
    logic                x_zero;
    logic                y_zero;
    logic                z_neg;
    logic                z_zero;
    logic [TAG_BITS-1:0] tag;
  } c2s_flags_t;

endpackage

`default_nettype wire

// ===== sv/cartesian_to_spherical_top.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical_top: pipelined Cartesian to spherical converter
// Throughput: one request per cycle while no result is held, set by the
// fully unrolled CORDIC stages. A stalled result holds the whole pipeline;
// nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; no state is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical_top #(
  parameter int CORDIC_STEPS = c2s_pkg::CORDIC_STEPS_DEF,
  parameter int DATA_BITS    = c2s_pkg::DATA_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire c2s_pkg::c2s_in_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output c2s_pkg::c2s_out_t out_data
);
  import c2s_pkg::*;

  localparam int W       = DATA_BITS + GUARD + 4;
  localparam int EXT     = (DATA_BITS > FIELD_BITS) ? DATA_BITS : FIELD_BITS;
  localparam int FLAGS_W = $bits(c2s_flags_t);
  localparam int SIDE1_W = FLAGS_W + W;
  localparam int SIDE2_W = FLAGS_W + FIELD_BITS + W;
  localparam int RQ_W    = W + 1 - GUARD;
  localparam logic [RQ_W-1:0] RMAX = RQ_W'((65'd1 << DATA_BITS) - 65'd1);
  localparam logic [W:0]      R_RND = (W + 1)'(1) << (GUARD - 1);

  // Reads the low DATA_BITS bits of a field as a signed value.
  function automatic logic signed [DATA_BITS-1:0] field_value(input logic [FIELD_BITS-1:0] f);
    logic [EXT-1:0] e;
    e = EXT'(f);
    return signed'(e[DATA_BITS-1:0]);
  endfunction

  logic en;

  // Input stage signals.
  logic signed [DATA_BITS-1:0] xv, yv, zv;
  logic signed [W-1:0]         xw, yw, zw, gx_nxt, gy_nxt, gz_nxt;
  c2s_flags_t                  flags_nxt;
  c2s_ctl_t                    p1_ctl_r;
  logic signed [W-1:0]         p1_x_r, p1_y_r;
  logic [SIDE1_W-1:0]          p1_side_r;

  // First pass outputs.
  logic                        v1;
  logic [W-1:0]                rho;
  logic [ANG_BITS-1:0]         ang1;
  logic [SIDE1_W-1:0]          side1;
  c2s_flags_t                  flags1;
  logic signed [W-1:0]         gz1;
  logic [FIELD_BITS-1:0]       a24, phi_nxt;

  // Second pass inputs and outputs.
  c2s_ctl_t                    p2_ctl_r;
  logic signed [W-1:0]         p2_x_r, p2_y_r;
  logic [SIDE2_W-1:0]          p2_side_r;
  logic                        v2;
  logic [W-1:0]                mag2;
  logic [ANG_BITS-1:0]         ang2;
  logic [SIDE2_W-1:0]          side2;
  c2s_flags_t                  flags2;
  logic [FIELD_BITS-1:0]       phi2;
  logic signed [W-1:0]         gz2;

  // Result stage signals.
  logic [W-1:0]                len;
  logic [W:0]                  rsum;
  logic [RQ_W-1:0]             rq;
  logic [DATA_BITS-1:0]        rsat;
  logic [EXT-1:0]              rext;
  logic signed [FIELD_BITS-1:0] b24, theta_nxt;
  c2s_out_t                    out_nxt, out_data_r;
  logic                        out_valid_r;

  // The whole pipeline advances unless a finished result is held.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Input stage: magnitudes with guard bits, and the sign and zero flags.
  always_comb begin
    xv = field_value(in_data.x_in);
    yv = field_value(in_data.y_in);
    zv = field_value(in_data.z_in);
    xw = W'(xv);
    yw = W'(yv);
    zw = W'(zv);
    gx_nxt = (xw < 0 ? -xw : xw) <<< GUARD;
    gy_nxt = (yw < 0 ? -yw : yw) <<< GUARD;
    gz_nxt = (zw < 0 ? -zw : zw) <<< GUARD;
    flags_nxt.x_neg  = xv[DATA_BITS-1];
    flags_nxt.y_neg  = yv[DATA_BITS-1];
    flags_nxt.x_zero = (xv == '0);
    flags_nxt.y_zero = (yv == '0);
    flags_nxt.z_neg  = zv[DATA_BITS-1];
    flags_nxt.z_zero = (zv == '0);
    flags_nxt.tag    = in_data.coord_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r <= '0;
    end else if (en) begin
      p1_ctl_r.valid <= in_valid;
      p1_ctl_r.skip  <= (gy_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x_r    <= gx_nxt;
      p1_y_r    <= gy_nxt;
      p1_side_r <= {flags_nxt, gz_nxt};
    end
  end

  // First pass: (|x|, |y|) gives rho and the first-quadrant angle.
  c2s_vector_pass #(
    .STEPS  (CORDIC_STEPS),
    .W      (W),
    .SIDE_W (SIDE1_W)
  ) u_pass_xy (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (p1_ctl_r),
    .x_i     (p1_x_r),
    .y_i     (p1_y_r),
    .side_i  (p1_side_r),
    .valid_o (v1),
    .mag_o   (rho),
    .ang_o   (ang1),
    .side_o  (side1)
  );

  // Quadrant placement of the azimuth.
  always_comb begin
    flags1 = c2s_flags_t'(side1[SIDE1_W-1:W]);
    gz1    = signed'(side1[W-1:0]);
    a24    = FIELD_BITS'(ang1);
    if (flags1.x_zero) begin
      phi_nxt = (!flags1.y_neg && !flags1.y_zero) ? QUARTER_TURN : THREE_QUARTER_TURN;
    end else if (flags1.y_zero) begin
      phi_nxt = flags1.x_neg ? HALF_TURN : '0;
    end else if (!flags1.x_neg && !flags1.y_neg) begin
      phi_nxt = a24;
    end else if (flags1.x_neg && !flags1.y_neg) begin
      phi_nxt = HALF_TURN - a24;
    end else if (flags1.x_neg) begin
      phi_nxt = HALF_TURN + a24;
    end else begin
      // Fourth quadrant: a full turn minus the angle, wrapping to zero.
      phi_nxt = '0 - a24;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_ctl_r <= '0;
    end else if (en) begin
      p2_ctl_r.valid <= v1;
      p2_ctl_r.skip  <= (gz1 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_x_r    <= signed'(rho);
      p2_y_r    <= gz1;
      p2_side_r <= {flags1, phi_nxt, gz1};
    end
  end

  // Second pass: (rho, |z|) gives the length and the elevation magnitude.
  c2s_vector_pass #(
    .STEPS  (CORDIC_STEPS),
    .W      (W),
    .SIDE_W (SIDE2_W)
  ) u_pass_rz (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (p2_ctl_r),
    .x_i     (p2_x_r),
    .y_i     (p2_y_r),
    .side_i  (p2_side_r),
    .valid_o (v2),
    .mag_o   (mag2),
    .ang_o   (ang2),
    .side_o  (side2)
  );

  // Result stage: elevation sign, radius rounding and saturation.
  always_comb begin
    flags2 = c2s_flags_t'(side2[SIDE2_W-1:W+FIELD_BITS]);
    phi2   = side2[W+FIELD_BITS-1:W];
    gz2    = signed'(side2[W-1:0]);
    b24    = signed'(FIELD_BITS'(ang2));
    if (flags2.x_zero && flags2.y_zero) begin
      // Vector on the z axis, or the zero vector, points straight up or down.
      theta_nxt = (!flags2.z_neg && !flags2.z_zero) ? signed'(QUARTER_TURN)
                                                    : -signed'(QUARTER_TURN);
      len = unsigned'(gz2);
    end else begin
      theta_nxt = flags2.z_neg ? -b24 : b24;
      len = mag2;
    end
    rsum = (W + 1)'(len) + R_RND;
    rq   = rsum[W:GUARD];
    rsat = (rq > RMAX) ? RMAX[DATA_BITS-1:0] : rq[DATA_BITS-1:0];
    rext = EXT'(rsat);
    out_nxt.radius    = rext[FIELD_BITS-1:0];
    out_nxt.azimuth   = phi2;
    out_nxt.elevation = theta_nxt;
    out_nxt.tag_out   = flags2.tag;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/c2s_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// c2s_cordic_stage: one registered CORDIC vectoring iteration
// Rotates (x, y) towards the x axis by atan(2^-SHIFT) and updates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic_stage #(
  parameter int W      = 34,
  parameter int SIDE_W = 8,
  parameter int SHIFT  = 0
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire c2s_pkg::c2s_ctl_t               ctl_i,
  input  wire logic signed [W-1:0]             x_i,
  input  wire logic signed [W-1:0]             y_i,
  input  wire logic signed [c2s_pkg::ACC_BITS-1:0] a_i,
  input  wire logic [SIDE_W-1:0]               side_i,
  output c2s_pkg::c2s_ctl_t                    ctl_o,
  output logic signed [W-1:0]                  x_o,
  output logic signed [W-1:0]                  y_o,
  output logic signed [c2s_pkg::ACC_BITS-1:0]  a_o,
  output logic [SIDE_W-1:0]                    side_o
);
  import c2s_pkg::*;

  localparam logic signed [ACC_BITS-1:0] STEP_ANGLE = ACC_BITS'(ATAN_TURN32[SHIFT]);

  c2s_ctl_t                    ctl_r;
  logic signed [W-1:0]         x_r, y_r, x_nxt, y_nxt;
  logic signed [ACC_BITS-1:0]  a_r, a_nxt;
  logic [SIDE_W-1:0]           side_r;
  logic signed [W-1:0]         dx, dy;

  // Shift-and-add rotation; a vector that started on the axis is held.
  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (ctl_i.skip) begin
      x_nxt = x_i;
      y_nxt = y_i;
      a_nxt = a_i;
    end else if (y_i > 0) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      a_nxt = a_i + STEP_ANGLE;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      a_nxt = a_i - STEP_ANGLE;
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      side_r <= side_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign a_o    = a_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// ===== sv/c2s_gain.sv =====
// ----------------------------------------------------------------------------
// c2s_gain: two-stage CORDIC gain removal
// Multiplies a magnitude by 1/K in Q31 in two partial products and rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_gain #(
  parameter int W = 34
) (
  input  wire              clk,
  input  wire              en,
  input  wire logic [W-1:0] v_i,
  output logic [W-1:0]     res_o
);
  import c2s_pkg::*;

  localparam int LO    = W / 2;
  localparam int HI    = W - LO;
  localparam int SUM_W = W + 32;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << 30;

  logic [LO+30:0]    pl_r, pl_nxt;
  logic [HI+30:0]    ph_r, ph_nxt;
  logic [SUM_W-1:0]  sum;
  logic [W-1:0]      res_r;

  // First stage: low and high partial products.
  always_comb begin
    pl_nxt = (LO + 31)'(v_i[LO-1:0]) * (LO + 31)'(INV_GAIN_Q31);
    ph_nxt = (HI + 31)'(v_i[W-1:LO]) * (HI + 31)'(INV_GAIN_Q31);
  end

  // Second stage: align, add the rounding half and drop the Q31 fraction.
  always_comb begin
    sum = (SUM_W'(ph_r) << LO) + SUM_W'(pl_r) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r  <= pl_nxt;
      ph_r  <= ph_nxt;
      res_r <= sum[W+30:31];
    end
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

// ===== sv/c2s_vector_pass.sv =====
// ----------------------------------------------------------------------------
// c2s_vector_pass: one pipelined CORDIC vectoring pass
// STEPS rotation stages, then angle clamp and rounding beside gain removal.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_vector_pass #(
  parameter int STEPS  = 24,
  parameter int W      = 34,
  parameter int SIDE_W = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire c2s_pkg::c2s_ctl_t   ctl_i,
  input  wire logic signed [W-1:0] x_i,
  input  wire logic signed [W-1:0] y_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     valid_o,
  output logic [W-1:0]             mag_o,
  output logic [c2s_pkg::ANG_BITS-1:0] ang_o,
  output logic [SIDE_W-1:0]        side_o
);
  import c2s_pkg::*;

  localparam logic signed [ACC_BITS-1:0] ANG_MAX = ACC_BITS'(1) << 30;
  localparam logic signed [ACC_BITS-1:0] ANG_RND = ACC_BITS'(128);

  c2s_ctl_t                   ctl_s  [STEPS+1];
  logic signed [W-1:0]        x_s    [STEPS+1];
  logic signed [W-1:0]        y_s    [STEPS+1];
  logic signed [ACC_BITS-1:0] a_s    [STEPS+1];
  logic [SIDE_W-1:0]          side_s [STEPS+1];

  c2s_ctl_t                   ctl_g1_r, ctl_g2_r;
  logic [ANG_BITS-1:0]        ang_g1_r, ang_g2_r, ang_nxt;
  logic [W-1:0]               xraw_g1_r, xraw_g2_r;
  logic [SIDE_W-1:0]          side_g1_r, side_g2_r;
  logic signed [ACC_BITS-1:0] a_clamp, a_round;
  logic [W-1:0]               gain_res;

  assign ctl_s[0]  = ctl_i;
  assign x_s[0]    = x_i;
  assign y_s[0]    = y_i;
  assign a_s[0]    = '0;
  assign side_s[0] = side_i;

  // Rotation stages.
  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    c2s_cordic_stage #(
      .W      (W),
      .SIDE_W (SIDE_W),
      .SHIFT  (i)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[i]),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .a_i    (a_s[i]),
      .side_i (side_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .a_o    (a_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  // Gain removal on the final x.
  c2s_gain #(
    .W (W)
  ) u_gain (
    .clk   (clk),
    .en    (en),
    .v_i   (unsigned'(x_s[STEPS])),
    .res_o (gain_res)
  );

  // Clamp the angle to a quarter turn and round into 2^-24 turn.
  always_comb begin
    if (a_s[STEPS] < 0) begin
      a_clamp = '0;
    end else if (a_s[STEPS] > ANG_MAX) begin
      a_clamp = ANG_MAX;
    end else begin
      a_clamp = a_s[STEPS];
    end
    a_round = a_clamp + ANG_RND;
    ang_nxt = a_round[30:8];
  end

  // Control registers beside the gain stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_g1_r <= '0;
      ctl_g2_r <= '0;
    end else if (en) begin
      ctl_g1_r <= ctl_s[STEPS];
      ctl_g2_r <= ctl_g1_r;
    end
  end

  // Data registers beside the gain stages.
  always_ff @(posedge clk) begin
    if (en) begin
      ang_g1_r  <= ang_nxt;
      ang_g2_r  <= ang_g1_r;
      xraw_g1_r <= unsigned'(x_s[STEPS]);
      xraw_g2_r <= xraw_g1_r;
      side_g1_r <= side_s[STEPS];
      side_g2_r <= side_g1_r;
    end
  end

  // A vector that started on the x axis keeps its length and a zero angle.
  assign valid_o = ctl_g2_r.valid;
  assign mag_o   = ctl_g2_r.skip ? xraw_g2_r : gain_res;
  assign ang_o   = ctl_g2_r.skip ? '0 : ang_g2_r;
  assign side_o  = side_g2_r;

endmodule

`default_nettype wire
